// ===== sv/ghi_pkg.sv =====
// Package for the gyro heading integrator: widths, fixed-point constants,
// payload structs and the sequencer state type. No dependencies.
`default_nettype none

package ghi_pkg;

    // Field widths
    localparam int RATE_W = 24;
    localparam int TIME_W = 32;
    localparam int HEAD_W = 26;
    localparam int DZ_W   = 24;
    localparam int CNT_W  = 8;
    localparam int SUM_W  = 32;

    // Serial arithmetic widths
    localparam int MUL_W     = 32;             // operand width of the serial multiplier
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DIV_NUM_W = 64;             // dividend and quotient width
    localparam int DIV_DEN_W = 20;             // divisor width (holds one million)
    localparam int H_W       = 45;             // heading sum before wrap and clamp
    localparam int DELTA_W   = 44;             // magnitude bits of the increment

    // Defaults and constants
    localparam int CAL_SAMPLES_DEF = 200;
    localparam logic [DZ_W-1:0] DEADZONE_RST = DZ_W'(13107);
    localparam logic [MUL_W-1:0] DEG_PER_RAD_Q16 = MUL_W'(3754936);
    localparam logic [DIV_DEN_W-1:0] US_PER_S = DIV_DEN_W'(1000000);
    localparam int HALF_TURN = 11796480;
    localparam int FULL_TURN = 23592960;
    localparam int FRAC_HALF = 32768;          // half of 2^16, for rounding the conversion

    typedef struct packed {
        logic signed [RATE_W-1:0] gyro_rate;
        logic [TIME_W-1:0]        time_us;
    } t_in_item;

    typedef struct packed {
        logic signed [HEAD_W-1:0] heading;
        logic                     calibrating;
        logic signed [RATE_W-1:0] bias;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL_DIV,
        ST_MUL_DEG,
        ST_CHK,
        ST_MUL_DT,
        ST_DIV_DT,
        ST_SUM,
        ST_WRAP,
        ST_SAT,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== sv/ghi_chan_if.sv =====
// Valid/ready channel carrying one payload beat of a chosen type.
// Used for the sample input, the result output and the deadzone write.
`default_nettype none

interface ghi_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/ghi_sermul.sv =====
// Radix-2 serial multiplier: one multiplier bit per cycle, unsigned operands.
// Depends on ghi_pkg for operand widths.
`default_nettype none

module ghi_sermul
    import ghi_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [MUL_W-1:0]  i_a,
    input  wire logic [MUL_W-1:0]  i_b,
    output logic                   o_done,
    output logic [PROD_W-1:0]      o_prod
);

    localparam int CW = $clog2(MUL_W);

    logic [PROD_W-1:0] r_p;
    logic [MUL_W-1:0]  r_a;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [MUL_W:0]    w_sum;

    // add the multiplicand into the upper half when the low bit is set
    assign w_sum = {1'b0, r_p[PROD_W-1:MUL_W]} + (r_p[0] ? {1'b0, r_a} : '0);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(MUL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift-add datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{MUL_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= {w_sum, r_p[MUL_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

`default_nettype wire

// ===== sv/ghi_serdiv.sv =====
// Restoring serial divider: one quotient bit per cycle, unsigned operands.
// Depends on ghi_pkg for dividend and divisor widths.
`default_nettype none

module ghi_serdiv
    import ghi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIV_NUM_W-1:0]  i_num,
    input  wire logic [DIV_DEN_W-1:0]  i_den,
    output logic                       o_done,
    output logic [DIV_NUM_W-1:0]       o_quot
);

    localparam int CW = $clog2(DIV_NUM_W);

    logic [DIV_NUM_W-1:0] r_q;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_DEN_W:0]   w_rem_sh;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_fits;

    // bring down the next dividend bit and try the subtraction
    assign w_rem_sh = {r_rem, r_q[DIV_NUM_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_den};
    assign w_fits   = (w_rem_sh >= {1'b0, r_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out at the top while quotient bits shift in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_NUM_W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[DIV_DEN_W-1:0] : w_rem_sh[DIV_DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ===== sv/gyro_heading_integrator.sv =====
// Gyro heading integrator with bias calibration; one item in flight at a time.
// Calibration and timestamp-only samples skip the serial units; the last calibration
// sample runs one serial divide; a sample within the deadzone runs one serial
// multiply; an integrated sample runs two serial multiplies and one serial divide.
// A new beat is taken once the previous result sits in the output register.
// Synchronous active-low reset.
`default_nettype none

module gyro_heading_integrator
    import ghi_pkg::*;
#(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ghi_chan_if.sink   i_gyro,
    ghi_chan_if.source o_head,
    ghi_chan_if.sink   i_cfg
);

    localparam logic [CNT_W-1:0]     CAL_N    = CNT_W'(CAL_SAMPLES);
    localparam logic [DIV_DEN_W-1:0] CAL_DEN  = DIV_DEN_W'(CAL_SAMPLES);
    localparam logic [DIV_NUM_W-1:0] CAL_HALF = DIV_NUM_W'(CAL_SAMPLES / 2);
    localparam logic [DIV_NUM_W-1:0] US_HALF  = DIV_NUM_W'(US_PER_S / 2);
    localparam logic [PROD_W-1:0]    RND_Q16  = PROD_W'(FRAC_HALF);
    localparam logic signed [H_W-1:0] HALF_H  = H_W'(HALF_TURN);
    localparam logic signed [H_W-1:0] FULL_H  = H_W'(FULL_TURN);

    t_state r_state, n_state;

    logic [DZ_W-1:0]          r_deadzone;
    logic [CNT_W-1:0]         r_cal_count;
    logic [SUM_W-1:0]         r_cal_sum;
    logic signed [RATE_W-1:0] r_bias;
    logic [TIME_W-1:0]        r_last_time;
    logic                     r_time_valid;
    logic signed [HEAD_W-1:0] r_heading;
    logic [TIME_W-1:0]        r_dt;
    logic                     r_neg;
    logic [MUL_W-1:0]         r_deg_mag;
    logic signed [H_W-1:0]    r_h;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic                  w_accept;
    logic                  w_calib;
    logic [SUM_W-1:0]      w_sum_nxt;
    logic [SUM_W:0]        w_sum_ext;
    logic [SUM_W:0]        w_sum_mag;
    logic [CNT_W-1:0]      w_cnt_nxt;
    logic [RATE_W:0]       w_corr;
    logic [RATE_W:0]       w_corr_mag;
    logic [PROD_W-1:0]     w_deg_rnd;
    logic [H_W-1:0]        w_delta_mag;
    logic                  w_load_out;

    logic                  w_mul_start;
    logic [MUL_W-1:0]      w_mul_a;
    logic [MUL_W-1:0]      w_mul_b;
    logic                  w_mul_done;
    logic [PROD_W-1:0]     w_prod;
    logic                  w_div_start;
    logic [DIV_NUM_W-1:0]  w_div_num;
    logic [DIV_DEN_W-1:0]  w_div_den;
    logic                  w_div_done;
    logic [DIV_NUM_W-1:0]  w_quot;

    ghi_sermul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    ghi_serdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // handshakes
    assign i_gyro.ready = (r_state == ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign w_accept     = i_gyro.valid && i_gyro.ready;
    assign w_calib      = (r_cal_count < CAL_N);
    assign o_head.valid = r_out_valid;
    assign o_head.data  = r_out;

    // calibration sum and its magnitude for the bias divide
    assign w_sum_nxt = r_cal_sum + SUM_W'(i_gyro.data.gyro_rate);
    assign w_sum_ext = {w_sum_nxt[SUM_W-1], w_sum_nxt};
    assign w_sum_mag = w_sum_nxt[SUM_W-1] ? (~w_sum_ext + 1'b1) : w_sum_ext;
    assign w_cnt_nxt = r_cal_count + 1'b1;

    // bias-corrected rate and its magnitude
    assign w_corr     = {i_gyro.data.gyro_rate[RATE_W-1], i_gyro.data.gyro_rate}
                      - {r_bias[RATE_W-1], r_bias};
    assign w_corr_mag = w_corr[RATE_W] ? (~w_corr + 1'b1) : w_corr;

    // rad/s to deg/s: round the Q16 product
    assign w_deg_rnd   = w_prod + RND_Q16;
    assign w_delta_mag = {1'b0, w_quot[DELTA_W-1:0]};

    assign w_load_out = (r_state == ST_OUT) && (!r_out_valid || o_head.ready);

    // sequencer: next state and serial unit requests
    always_comb begin
        n_state     = r_state;
        w_mul_start = 1'b0;
        w_mul_a     = MUL_W'(w_corr_mag);
        w_mul_b     = DEG_PER_RAD_Q16;
        w_div_start = 1'b0;
        w_div_num   = DIV_NUM_W'(w_sum_mag) + CAL_HALF;
        w_div_den   = CAL_DEN;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    priority if (w_calib) begin
                        if (w_cnt_nxt >= CAL_N) begin
                            w_div_start = 1'b1;
                            n_state     = ST_CAL_DIV;
                        end else begin
                            n_state = ST_OUT;
                        end
                    end else if (!r_time_valid) begin
                        n_state = ST_OUT;
                    end else begin
                        w_mul_start = 1'b1;
                        n_state     = ST_MUL_DEG;
                    end
                end
            end
            ST_CAL_DIV: begin
                if (w_div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_MUL_DEG: begin
                if (w_mul_done) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                w_mul_a = r_deg_mag;
                w_mul_b = r_dt;
                if (r_deg_mag > MUL_W'(r_deadzone)) begin
                    w_mul_start = 1'b1;
                    n_state     = ST_MUL_DT;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_MUL_DT: begin
                w_div_num = w_prod + US_HALF;
                w_div_den = US_PER_S;
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV_DT;
                end
            end
            ST_DIV_DT: begin
                if (w_div_done) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM:  n_state = ST_WRAP;
            ST_WRAP: n_state = ST_SAT;
            ST_SAT:  n_state = ST_OUT;
            ST_OUT: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // block state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone   <= DEADZONE_RST;
            r_cal_count  <= '0;
            r_cal_sum    <= '0;
            r_bias       <= '0;
            r_last_time  <= '0;
            r_time_valid <= 1'b0;
            r_heading    <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_deadzone <= i_cfg.data;
            end
            // take the beat: calibrate, record time, or set up the integration
            if (w_accept) begin
                priority if (w_calib) begin
                    r_cal_sum   <= w_sum_nxt;
                    r_cal_count <= w_cnt_nxt;
                end else if (!r_time_valid) begin
                    r_last_time  <= i_gyro.data.time_us;
                    r_time_valid <= 1'b1;
                end else begin
                    r_last_time <= i_gyro.data.time_us;
                end
            end
            // apply the rounded average
            if (r_state == ST_CAL_DIV && w_div_done) begin
                r_bias <= r_neg ? -w_quot[RATE_W-1:0] : w_quot[RATE_W-1:0];
            end
            // clamp to a full turn and store
            if (r_state == ST_SAT) begin
                priority if (r_h > FULL_H) begin
                    r_heading <= HEAD_W'(FULL_H);
                end else if (r_h < -FULL_H) begin
                    r_heading <= HEAD_W'(-FULL_H);
                end else begin
                    r_heading <= r_h[HEAD_W-1:0];
                end
            end
        end
    end

    // working registers of one item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dt  <= i_gyro.data.time_us - r_last_time;
            r_neg <= w_calib ? w_sum_nxt[SUM_W-1] : w_corr[RATE_W];
        end
        if (r_state == ST_MUL_DEG && w_mul_done) begin
            r_deg_mag <= w_deg_rnd[MUL_W+15:16];
        end
        unique case (r_state)
            ST_DIV_DT: begin
                if (w_div_done) begin
                    r_h <= r_neg ? -signed'(w_delta_mag) : signed'(w_delta_mag);
                end
            end
            ST_SUM:  r_h <= r_h + H_W'(r_heading);
            ST_WRAP: begin
                priority if (r_h > HALF_H) begin
                    r_h <= r_h - FULL_H;
                end else if (r_h < -HALF_H) begin
                    r_h <= r_h + FULL_H;
                end else begin
                    r_h <= r_h;
                end
            end
            default: begin
            end
        endcase
    end

    // output register: hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_head.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out.heading     <= r_heading;
            r_out.calibrating <= w_calib;
            r_out.bias        <= r_bias;
        end
    end

endmodule

`default_nettype wire

// ===== tb/heading_checker.sv =====
// Scoreboard for the gyro heading integrator: watches the sample, result and
// deadzone channels, predicts every result beat and compares it field by field.
// Depends on ghi_pkg for the beat types and field widths.
`timescale 1ns / 1ps

module heading_checker
    import ghi_pkg::*;
#(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_gyro_valid,
    input  wire logic             i_gyro_ready,
    input  wire t_in_item         i_gyro_data,
    input  wire logic             i_head_valid,
    input  wire logic             i_head_ready,
    input  wire t_out_item        i_head_data,
    input  wire logic             i_cfg_valid,
    input  wire logic             i_cfg_ready,
    input  wire logic [DZ_W-1:0]  i_cfg_data,
    output int                    o_pending,
    output int                    o_fails
);

    // Fixed-point constants of the heading arithmetic
    localparam longint DEG_SCALE  = 3754936;   // 180/pi in Q16
    localparam longint Q16_ONE    = 65536;
    localparam longint US_PER_SEC = 1000000;
    localparam longint HALF_REV   = 11796480;  // 180 degrees in Q16
    localparam longint FULL_REV   = 23592960;  // 360 degrees in Q16
    localparam logic [DZ_W-1:0] DZ_AT_RESET = DZ_W'(13107);
    localparam int MAX_PRINTED = 40;

    // Predicted block state
    int                       cal_taken;
    logic [SUM_W-1:0]         cal_total;
    logic signed [RATE_W-1:0] bias_est;
    logic [TIME_W-1:0]        prev_stamp;
    logic                     stamp_seen;
    longint                   heading_now;
    logic [DZ_W-1:0]          deadzone;
    t_out_item                heading_due[$];

    // Divide rounding to nearest, ties away from zero
    function automatic longint div_nearest(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // Advance the predicted state by one sample and queue the result it gives
    function automatic void integrate_sample(t_in_item s);
        longint            rate;
        longint            corr;
        longint            deg;
        longint            mag;
        longint            h;
        logic [TIME_W-1:0] dt;
        t_out_item         r;
        rate = longint'($signed(s.gyro_rate));
        if (cal_taken < CAL_SAMPLES) begin
            // accumulate the bias average, complete it on the last sample
            cal_total = cal_total + rate[SUM_W-1:0];
            cal_taken++;
            if (cal_taken >= CAL_SAMPLES)
                bias_est = RATE_W'(div_nearest(longint'($signed(cal_total)), CAL_SAMPLES));
        end else if (!stamp_seen) begin
            // first sample after calibration: record its time only
            prev_stamp = s.time_us;
            stamp_seen = 1'b1;
        end else begin
            dt = s.time_us - prev_stamp;
            prev_stamp = s.time_us;
            corr = rate - longint'(bias_est);
            deg = div_nearest(corr * DEG_SCALE, Q16_ONE);
            mag = (deg < 0) ? -deg : deg;
            if (mag > longint'(deadzone)) begin
                h = heading_now + div_nearest(deg * longint'(dt), US_PER_SEC);
                // wrap once toward +-180, then clamp to +-360
                if (h > HALF_REV)
                    h -= FULL_REV;
                else if (h < -HALF_REV)
                    h += FULL_REV;
                if (h > FULL_REV)
                    h = FULL_REV;
                else if (h < -FULL_REV)
                    h = -FULL_REV;
                heading_now = h;
            end
        end
        r.heading     = HEAD_W'(heading_now);
        r.calibrating = (cal_taken < CAL_SAMPLES);
        r.bias        = bias_est;
        heading_due.push_back(r);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (o_fails < MAX_PRINTED)
            $display("%0t heading_checker: %s got %0d, want %0d", $time, what, got, want);
        o_fails++;
    endtask

    // Track configuration, predict on sample beats, compare on result beats
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cal_taken   = 0;
            cal_total   = '0;
            bias_est    = '0;
            prev_stamp  = '0;
            stamp_seen  = 1'b0;
            heading_now = 0;
            deadzone    = DZ_AT_RESET;
            heading_due.delete();
            o_pending   = 0;
            o_fails     = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                deadzone = i_cfg_data;
            if (i_gyro_valid && i_gyro_ready)
                integrate_sample(i_gyro_data);
            if (i_head_valid && i_head_ready) begin
                if (heading_due.size() == 0) begin
                    report_mismatch("result beat with none pending, heading",
                                    longint'($signed(i_head_data.heading)), 0);
                end else begin
                    want = heading_due.pop_front();
                    if (i_head_data.heading !== want.heading)
                        report_mismatch("heading", longint'($signed(i_head_data.heading)),
                                        longint'($signed(want.heading)));
                    if (i_head_data.calibrating !== want.calibrating)
                        report_mismatch("calibrating", longint'(i_head_data.calibrating),
                                        longint'(want.calibrating));
                    if (i_head_data.bias !== want.bias)
                        report_mismatch("bias", longint'($signed(i_head_data.bias)),
                                        longint'($signed(want.bias)));
                end
            end
            o_pending = heading_due.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the gyro heading integrator testbench: clock, reset, sample and
// deadzone stimulus, result back-pressure and the verdict.
// Depends on ghi_pkg, ghi_chan_if, gyro_heading_integrator and heading_checker.
`timescale 1ns / 1ps

module testbench;
    import ghi_pkg::*;

    localparam int CAL_N       = CAL_SAMPLES_DEF;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_WAIT  = 200;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 245;
    localparam int RATE_MAX    = 8388607;
    localparam int RATE_MIN    = -8388608;

    typedef logic [DZ_W-1:0] t_deadzone;

    logic clk = 1'b0;
    logic rst_n;
    int   pending;
    int   fails;
    bit   hold_off;
    bit   no_idle;
    int   bias_now;
    logic [TIME_W-1:0] stamp;

    always #6 clk = ~clk;

    ghi_chan_if #(.T(t_in_item))  gyro_ch ();
    ghi_chan_if #(.T(t_out_item)) head_ch ();
    ghi_chan_if #(.T(t_deadzone)) cfg_ch ();

    gyro_heading_integrator #(
        .CAL_SAMPLES(CAL_N)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_gyro  (gyro_ch.sink),
        .o_head  (head_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    heading_checker #(
        .CAL_SAMPLES(CAL_N)
    ) heading_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_gyro_valid (gyro_ch.valid),
        .i_gyro_ready (gyro_ch.ready),
        .i_gyro_data  (gyro_ch.data),
        .i_head_valid (head_ch.valid),
        .i_head_ready (head_ch.ready),
        .i_head_data  (head_ch.data),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg_data   (cfg_ch.data),
        .o_pending    (pending),
        .o_fails      (fails)
    );

    // Idle cycles before the next beat on either side
    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // Offer one sample beat and hold it until taken
    task automatic put_sample(int rate_v, logic [TIME_W-1:0] stamp_v);
        int       gap;
        t_in_item beat;
        gap = draw_gap();
        beat.gyro_rate = rate_v[RATE_W-1:0];
        beat.time_us   = stamp_v;
        if (gap > 0) begin
            gyro_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        gyro_ch.valid <= 1'b1;
        gyro_ch.data  <= beat;
        do @(posedge clk); while (!gyro_ch.ready);
        @(negedge clk);
    endtask

    task automatic step_by(int rate_v, logic [TIME_W-1:0] dt);
        stamp = stamp + dt;
        put_sample(rate_v, stamp);
    endtask

    // Stop offering and wait for every pending result
    task automatic settle();
        gyro_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic write_deadzone(t_deadzone v);
        settle();
        cfg_ch.data  <= v;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly rates around the bias at various magnitudes, some over the full range
    function automatic int random_rate();
        int offs;
        case ($urandom_range(0, 9))
            0: return int'($urandom_range(0, 24'hFFFFFF)) + RATE_MIN;
            1: offs = int'($urandom_range(0, 600)) - 300;
            2, 3, 4, 5, 6: offs = int'($urandom_range(0, 100000)) - 50000;
            7, 8: offs = int'($urandom_range(0, 2000000)) - 1000000;
            default: offs = ($urandom_range(0, 1) ? 4096 : 8192) * ($urandom_range(0, 1) ? 1 : -1);
        endcase
        return bias_now + offs;
    endfunction

    task automatic random_sample();
        case ($urandom_range(0, 9))
            0: step_by(random_rate(), 0);
            7: step_by(random_rate(), $urandom_range(0, 2000000));
            8: begin
                stamp = $urandom();
                put_sample(random_rate(), stamp);
            end
            9: step_by(random_rate(), 500000);
            default: step_by(random_rate(), $urandom_range(0, 200000));
        endcase
    endtask

    // Stimulus: calibration, directed corner cases, then random phases
    initial begin : stimulus
        int        cal_run;
        int        bias_goal;
        int        goal_sum;
        int        rate;
        t_deadzone dz;
        rst_n         = 1'b0;
        gyro_ch.valid = 1'b0;
        gyro_ch.data  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        hold_off      = 1'b0;
        no_idle       = 1'b0;
        stamp         = '0;
        bias_now      = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // calibration: rate extremes, noise around a chosen bias, and a last
        // sample that puts the average exactly on a rounding tie
        bias_goal = int'($urandom_range(0, 10000)) - 5000;
        put_sample(RATE_MAX, 32'h0000_0000);
        put_sample(RATE_MIN, 32'hFFFF_FFFF);
        cal_run = RATE_MAX + RATE_MIN;
        for (int k = 2; k < CAL_N - 1; k++) begin
            rate = bias_goal + int'($urandom_range(0, 4000)) - 2000;
            cal_run += rate;
            put_sample(rate, $urandom());
        end
        goal_sum = bias_goal * CAL_N + ((bias_goal >= 0) ? CAL_N / 2 : -(CAL_N / 2));
        put_sample(goal_sum - cal_run, $urandom());
        bias_now = bias_goal + ((bias_goal >= 0) ? 1 : -1);

        // first sample after calibration only records its time
        stamp = 32'd1000;
        put_sample(int'($urandom_range(0, 24'hFFFFFF)) + RATE_MIN, stamp);

        // reset deadzone: zero rate, conversion and increment ties, deadzone edge
        step_by(bias_now, 20000);
        step_by(bias_now + 4096, 500000);
        step_by(bias_now - 4096, 500000);
        step_by(bias_now + 8192, 500000);
        step_by(bias_now - 8192, 500000);
        step_by(bias_now + 228, 100000);
        step_by(bias_now + 229, 100000);
        // large increments: wrap then clamp, zero time step, backwards time
        step_by(RATE_MAX, 250000);
        step_by(bias_now + 100000, 1000000);
        step_by(RATE_MIN, 0);
        step_by(bias_now + 50000, 32'hFFFF_FFFF);
        step_by(bias_now - 50000, 32'hFFFF_FFFF);
        step_by(bias_now + 200000, 100000);
        // timestamp rolling over forward
        stamp = 32'hFFFF_FF00;
        put_sample(bias_now, stamp);
        step_by(bias_now + 30000, 32'h200);

        // deadzone at both extremes
        write_deadzone('0);
        step_by(bias_now, 1000);
        step_by(bias_now + 1, 1000000);
        step_by(bias_now - 1, 1000000);
        write_deadzone('1);
        step_by(bias_now + 200000, 100000);
        step_by(bias_now + 300000, 100000);
        step_by(RATE_MIN, 100000);

        // random phases, each with its own deadzone
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: dz = t_deadzone'($urandom());
                1: dz = '0;
                2: dz = t_deadzone'($urandom_range(0, 60000));
                3: dz = '1;
                4: dz = DEADZONE_RST;
                default: dz = t_deadzone'($urandom_range(0, 20000));
            endcase
            write_deadzone(dz);
            no_idle = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 40)
                    hold_off = 1'b1;
                random_sample();
            end
        end

        settle();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Result side: random stalls per beat, one long hold-off on request
    initial begin : result_sink
        int stall;
        head_ch.ready = 1'b0;
        @(negedge clk);
        forever begin
            if (hold_off) begin
                stall = HOLD_CYCLES;
                hold_off = 1'b0;
            end else begin
                stall = draw_gap();
            end
            if (stall > 0) begin
                head_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            head_ch.ready <= 1'b1;
            do @(posedge clk); while (!(head_ch.valid && head_ch.ready));
            @(negedge clk);
        end
    end

    // Abort when no beat moves on any channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((gyro_ch.valid && gyro_ch.ready) || (head_ch.valid && head_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule
